### rtl/core/planar_pose_predictor_assert.svh
// Assertion macros for the planar pose predictor.
`ifndef PLANAR_POSE_PREDICTOR_ASSERT_SVH
`define PLANAR_POSE_PREDICTOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PPP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("planar_pose_predictor: assertion failed");

// Check that a trigger implies a consequence in the next cycle.
`define PPP_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("planar_pose_predictor: sequence check failed");

`endif

### rtl/core/ppp_pkg.sv
// Shared constants and tables for the planar pose predictor.
package ppp_pkg;

  localparam int POS_W      = 32;
  localparam int HEAD_W     = 17;
  localparam int CMD_W      = 16;
  localparam int STEP_W     = 15;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W     = 31;

  localparam int TRIG_ITERATIONS_DEF = 16;

  localparam logic [STEP_W-1:0] STEP_TIME_RST = 15'd6554;

  localparam logic signed [HEAD_W-1:0] PI_Q13      = 17'sd25736;
  localparam logic signed [HEAD_W-1:0] TWO_PI_Q13  = 17'sd51472;
  localparam logic signed [HEAD_W-1:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [HEAD_W-1:0] HEAD_LIMIT  = 17'sd51472;

  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:    r = 31'd843314857;
      5'd1:    r = 31'd497837830;
      5'd2:    r = 31'd263043837;
      5'd3:    r = 31'd133525159;
      5'd4:    r = 31'd67021687;
      5'd5:    r = 31'd33543516;
      5'd6:    r = 31'd16775851;
      5'd7:    r = 31'd8388437;
      5'd8:    r = 31'd4194283;
      5'd9:    r = 31'd2097149;
      5'd10:   r = 31'd1048576;
      5'd11:   r = 31'd524288;
      5'd12:   r = 31'd262144;
      5'd13:   r = 31'd131072;
      5'd14:   r = 31'd65536;
      5'd15:   r = 31'd32768;
      5'd16:   r = 31'd16384;
      5'd17:   r = 31'd8192;
      5'd18:   r = 31'd4096;
      5'd19:   r = 31'd2048;
      5'd20:   r = 31'd1024;
      5'd21:   r = 31'd512;
      5'd22:   r = 31'd256;
      5'd23:   r = 31'd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/ppp_if.sv
// Valid/ready channel interfaces for pose commands and pose results.
interface ppp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [ppp_pkg::POS_W-1:0]     pose_x;
  logic signed [ppp_pkg::POS_W-1:0]     pose_y;
  logic signed [ppp_pkg::HEAD_W-1:0]    pose_heading;
  logic signed [ppp_pkg::CMD_W-1:0]     cmd_vx;
  logic signed [ppp_pkg::CMD_W-1:0]     cmd_vy;
  logic signed [ppp_pkg::CMD_W-1:0]     cmd_w;

  modport source (
    output valid, mode, pose_x, pose_y, pose_heading, cmd_vx, cmd_vy, cmd_w,
    input  ready
  );
  modport sink (
    input  valid, mode, pose_x, pose_y, pose_heading, cmd_vx, cmd_vy, cmd_w,
    output ready
  );
endinterface

interface ppp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ppp_pkg::POS_W-1:0]     out_x;
  logic signed [ppp_pkg::POS_W-1:0]     out_y;
  logic signed [ppp_pkg::HEAD_W-1:0]    out_heading;

  modport source (
    output valid, out_x, out_y, out_heading,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_heading,
    output ready
  );
endinterface

### rtl/core/planar_pose_predictor.sv
// Planar pose predictor: load or dead-reckon one pose per command transfer.
//
//   channel | dir | payload                                       | handshake
//   req     | in  | mode, pose_x/y, pose_heading, cmd_vx/vy/w     | valid/ready
//   rsp     | out | out_x, out_y, out_heading                     | valid/ready
//   cfg     | in  | cfg_data (step_time)                          | cfg_we
//
// A load goes from the transfer straight to S_FIN; a step first runs S_ROT, where
// one shift-add CORDIC unit runs one iteration per cycle, then S_MUL, where
// one shared 48x17 multiplier runs seven products back to back, then S_FIN.
// req.ready is high only in idle; the result register holds until rsp transfers.
// Synchronous reset clears the pose to zero and step_time to 6554.
module planar_pose_predictor #(
  parameter int TRIG_ITERATIONS = ppp_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ppp_pkg::STEP_W-1:0]    cfg_data,
  ppp_in_if.sink                        req,
  ppp_out_if.source                     rsp
);

  `include "planar_pose_predictor_assert.svh"

  localparam int IT_W = $clog2(TRIG_ITERATIONS);
  localparam int AIW  = ppp_pkg::ATAN_IDX_W;
  localparam logic [IT_W-1:0] IT_LAST  = IT_W'(TRIG_ITERATIONS - 1);
  localparam logic [2:0]      MUL_LAST = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROT  = 4'b0010,
    S_MUL  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [ppp_pkg::STEP_W-1:0]          step_time;
  logic signed [ppp_pkg::POS_W-1:0]    held_x, held_y;
  logic signed [ppp_pkg::HEAD_W-1:0]   held_heading;
  logic signed [ppp_pkg::HEAD_W-1:0]   heading;
  logic signed [ppp_pkg::CMD_W-1:0]    vx, vy, w;
  logic                                flip;
  logic signed [32:0]                  cx, cy, cz;
  logic [IT_W-1:0]                     it;
  logic [2:0]                          k;
  logic signed [63:0]                  prod;
  logic signed [47:0]                  t0, t1;
  logic                                out_valid;
  logic signed [ppp_pkg::POS_W-1:0]    out_x, out_y;
  logic signed [ppp_pkg::HEAD_W-1:0]   out_heading;

  logic signed [ppp_pkg::HEAD_W-1:0]   h_wrap, h_fold;
  logic                                fold;
  logic [AIW-1:0]                      shamt;
  logic signed [32:0]                  xs, ys, atan_e;
  logic signed [16:0]                  vx_e, vy_e, ts_e;
  logic signed [47:0]                  mul_a;
  logic signed [16:0]                  mul_b;
  logic signed [64:0]                  mul_p;
  logic signed [63:0]                  rnd_pos, rnd_head;
  logic signed [33:0]                  pos_sum;
  logic signed [18:0]                  head_sum;
  logic signed [ppp_pkg::POS_W-1:0]    pos_held, pos_sat;
  logic signed [ppp_pkg::HEAD_W-1:0]   head_sat;
  logic                                req_xfer, out_free;

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.out_x       = out_x;
  assign rsp.out_y       = out_y;
  assign rsp.out_heading = out_heading;

  // wrap once by 2*pi, then fold into the CORDIC range
  always_comb begin
    priority if (held_heading >= ppp_pkg::PI_Q13) begin
      h_wrap = held_heading - ppp_pkg::TWO_PI_Q13;
    end else if (held_heading <= -ppp_pkg::PI_Q13) begin
      h_wrap = held_heading + ppp_pkg::TWO_PI_Q13;
    end else begin
      h_wrap = held_heading;
    end
    priority if (h_wrap > ppp_pkg::HALF_PI_Q13) begin
      h_fold = h_wrap - ppp_pkg::PI_Q13;
      fold   = 1'b1;
    end else if (h_wrap < -ppp_pkg::HALF_PI_Q13) begin
      h_fold = h_wrap + ppp_pkg::PI_Q13;
      fold   = 1'b1;
    end else begin
      h_fold = h_wrap;
      fold   = 1'b0;
    end
  end

  assign shamt  = AIW'(it);
  assign xs     = cx >>> shamt;
  assign ys     = cy >>> shamt;
  assign atan_e = signed'({2'b00, ppp_pkg::atan_q30(shamt)});

  assign vx_e = flip ? -17'(vx) : 17'(vx);
  assign vy_e = flip ? -17'(vy) : 17'(vy);
  assign ts_e = signed'({2'b00, step_time});

  always_comb begin
    unique case (k)
      3'd0: begin mul_a = 48'(cx); mul_b = vx_e; end
      3'd1: begin mul_a = 48'(cy); mul_b = vy_e; end
      3'd2: begin mul_a = 48'(cy); mul_b = vx_e; end
      3'd3: begin mul_a = 48'(cx); mul_b = vy_e; end
      3'd4: begin mul_a = t0;      mul_b = ts_e; end
      3'd5: begin mul_a = t1;      mul_b = ts_e; end
      default: begin mul_a = 48'(w); mul_b = ts_e; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rnd_pos  = prod + 64'sd2199023255552;
  assign rnd_head = prod + 64'sd16384;
  assign pos_held = (k == 3'd5) ? held_x : held_y;
  assign pos_sum  = 34'(pos_held) + 34'(signed'(rnd_pos[63:42]));
  assign head_sum = 19'(heading) + 19'(signed'(rnd_head[32:15]));

  always_comb begin
    priority if (pos_sum > 34'sd2147483647) begin
      pos_sat = 32'sh7FFFFFFF;
    end else if (pos_sum < -34'sd2147483648) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
    priority if (head_sum > 19'(ppp_pkg::HEAD_LIMIT)) begin
      head_sat = ppp_pkg::HEAD_LIMIT;
    end else if (head_sum < -19'(ppp_pkg::HEAD_LIMIT)) begin
      head_sat = -ppp_pkg::HEAD_LIMIT;
    end else begin
      head_sat = head_sum[ppp_pkg::HEAD_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          state_next = (req.mode == ppp_pkg::MODE_STEP) ? S_ROT : S_FIN;
        end
      end
      S_ROT: begin
        if (it == IT_LAST) state_next = S_MUL;
      end
      S_MUL: begin
        if (k == MUL_LAST) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_time    <= ppp_pkg::STEP_TIME_RST;
      held_x       <= '0;
      held_y       <= '0;
      held_heading <= '0;
      out_valid    <= 1'b0;
      it           <= '0;
      k            <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) step_time <= cfg_data;
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            if (req.mode == ppp_pkg::MODE_LOAD) begin
              held_x       <= req.pose_x;
              held_y       <= req.pose_y;
              held_heading <= req.pose_heading;
            end
            it <= '0;
            k  <= '0;
          end
        end
        S_ROT: begin
          it <= it + 1'b1;
        end
        S_MUL: begin
          k <= k + 1'b1;
          unique case (k)
            3'd5: held_x <= pos_sat;
            3'd6: held_y <= pos_sat;
            3'd7: held_heading <= head_sat;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        heading <= h_wrap;
        flip    <= fold;
        vx      <= req.cmd_vx;
        vy      <= req.cmd_vy;
        w       <= req.cmd_w;
        cx      <= ppp_pkg::CORDIC_GAIN_Q30;
        cy      <= '0;
        cz      <= signed'({h_fold, 16'd0}) <<< 1;
      end
      S_ROT: begin
        if (!cz[32]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_e;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_e;
        end
      end
      S_MUL: begin
        prod <= mul_p[63:0];
        unique case (k)
          3'd1: t0 <= prod[47:0];
          3'd2: t0 <= t0 - prod[47:0];
          3'd3: t1 <= prod[47:0];
          3'd4: t1 <= t1 + prod[47:0];
          default: ;
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          out_x       <= held_x;
          out_y       <= held_y;
          out_heading <= held_heading;
        end
      end
      default: ;
    endcase
  end

  `PPP_ASSERT_NEXT(a_step_starts_rotation, clk, rst,
    req_xfer && (req.mode == ppp_pkg::MODE_STEP), state == S_ROT)
  `PPP_ASSERT_NEXT(a_load_sets_pose, clk, rst,
    req_xfer && (req.mode == ppp_pkg::MODE_LOAD),
    (state == S_FIN) && (held_x == $past(req.pose_x)) && (held_y == $past(req.pose_y)))
  `PPP_ASSERT_NEXT(a_finish_presents_result, clk, rst,
    (state == S_FIN) && out_free, out_valid && (out_x == $past(held_x)))
  `PPP_ASSERT(a_iteration_bound, clk, rst, (state != S_ROT) || (it <= IT_LAST))

endmodule
